// ===== src/awu_pkg.sv =====
// Shared types and constants of the Adam weight update unit.
// Depends on nothing; every other file imports it.
`default_nettype none
package awu_pkg;

	localparam int unsigned ADDR_W = 4;

	// Register indexes on the configuration port (paddr[3:2]).
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_LR  = 2'd0;
	localparam reg_idx_t REG_BS  = 2'd1;
	localparam reg_idx_t REG_BC1 = 2'd2;
	localparam reg_idx_t REG_BC2 = 2'd3;

	localparam logic [24:0] LR_RST = 25'd16777;
	localparam logic [15:0] BS_RST = 16'd1;
	localparam logic [31:0] BC_RST = 32'd1048576;

	// Betas in Q2.30.
	localparam logic signed [31:0] B1_Q30   = 32'sd966367642;
	localparam logic signed [31:0] OMB1_Q30 = 32'sd107374182;
	localparam logic [29:0]        B2_Q30   = 30'd1072668082;
	localparam logic [20:0]        OMB2_Q30 = 21'd1073742;

	localparam logic [42:0] G2_CAP   = 43'd1 << 42;
	localparam logic [40:0] STEP_CAP = 41'd1 << 40;

	// Pipeline stage map.
	localparam int DIV_N   = 32;
	localparam int S_DIV0  = 1;
	localparam int S_MUL   = S_DIV0 + DIV_N;
	localparam int S_MRND  = S_MUL + 1;
	localparam int S_VMUL  = S_MRND + 1;
	localparam int S_VRND  = S_VMUL + 1;
	localparam int S_CMUL  = S_VRND + 1;
	localparam int S_CRND  = S_CMUL + 1;
	localparam int SQ_N    = 32;
	localparam int S_SQ0   = S_CRND + 1;
	localparam int S_NUM   = S_SQ0 + SQ_N;
	localparam int S_QINIT = S_NUM + 1;
	localparam int QD_N    = 41;
	localparam int S_QD0   = S_QINIT + 1;
	localparam int S_FIN   = S_QD0 + QD_N;
	localparam int LAST    = S_FIN;

	typedef struct packed {
		logic [24:0] lr;
		logic [15:0] bs;
		logic [31:0] bc1;
		logic [31:0] bc2;
	} cfg_t;

	// Working record that travels down the pipeline.
	typedef struct packed {
		logic signed [31:0] w;
		logic signed [31:0] m;
		logic [31:0]        v;
		logic               sat;
		logic               gneg;
		logic [31:0]        a;
		logic [31:0]        q;
		logic [15:0]        drem;
		logic signed [63:0] pm1;
		logic signed [63:0] pm2;
		logic [63:0]        gg;
		logic [61:0]        pv;
		logic [42:0]        g2;
		logic [63:0]        pg;
		logic signed [64:0] mhp;
		logic [63:0]        vb;
		logic               mneg;
		logic [43:0]        mag;
		logic [63:0]        sx;
		logic [31:0]        root;
		logic [35:0]        srem;
		logic [68:0]        num;
		logic [32:0]        dd;
		logic               ovf;
		logic [33:0]        qrem;
		logic [40:0]        qd;
	} rec_t;

	typedef struct packed {
		logic signed [31:0] w;
		logic signed [31:0] m;
		logic [31:0]        v;
		logic               sat;
	} res_t;

endpackage
`default_nettype wire

// ===== src/awu_cfg.sv =====
// Configuration register file of the Adam weight update unit, APB-style.
// Depends on awu_pkg.
`default_nettype none
module awu_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [awu_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output awu_pkg::cfg_t               cfg
);
	import awu_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lr  <= LR_RST;
			cfg_q.bs  <= BS_RST;
			cfg_q.bc1 <= BC_RST;
			cfg_q.bc2 <= BC_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_LR:  cfg_q.lr  <= pwdata[24:0];
				REG_BS:  cfg_q.bs  <= pwdata[15:0];
				REG_BC1: cfg_q.bc1 <= pwdata;
				REG_BC2: cfg_q.bc2 <= pwdata;
				default: cfg_q.bc2 <= cfg_q.bc2;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LR:  prdata = {7'd0, cfg_q.lr};
			REG_BS:  prdata = {16'd0, cfg_q.bs};
			REG_BC1: prdata = cfg_q.bc1;
			REG_BC2: prdata = cfg_q.bc2;
			default: prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== src/adam_weight_update_unit.sv =====
// Top level of the Adam weight update unit: pipelined datapath and output skid.
// Depends on awu_pkg and awu_cfg.
//
//   Channel   Signals                                   Beat content
//   input     in_valid / in_ready                       weight_in, moment_first_in,
//                                                       moment_second_in, grad_sum
//   output    out_valid / out_ready                     weight_out, moment_first_out,
//                                                       moment_second_out, saturated
//   config    psel penable pwrite paddr pwdata prdata   four registers
//
// One beat is accepted per cycle while the skid register is empty; a record passes 115
// pipeline registers, the first loaded at the edge that accepts it, among them the 32 steps
// of the batch divider, the 32 steps of the square root and the 41 steps of the step
// divider, and then the output register.
// Reset clears all valid bits and loads the register defaults; data needs no reset.
// The pipeline moves as one; it halts only while the skid register is full,
// so the skid register takes the one result that arrives while the output register is held.
`default_nettype none
module adam_weight_update_unit #(
	parameter int FRAC_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [awu_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [31:0]          weight_in,
	input  logic signed [31:0]          moment_first_in,
	input  logic [31:0]                 moment_second_in,
	input  logic signed [31:0]          grad_sum,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          weight_out,
	output logic signed [31:0]          moment_first_out,
	output logic [31:0]                 moment_second_out,
	output logic                        saturated
);
	import awu_pkg::*;

	// Right shift that brings the gradient square from Q.2F to Q.28.
	localparam int G2_SH = 2 * FRAC_BITS - 28;

	cfg_t              cfg;
	logic [15:0]       dvs;
	logic              en;
	logic [LAST:0]     vld_s;
	rec_t              rec_s [0:LAST];
	rec_t              nxt   [0:LAST];
	res_t              out_q;
	res_t              skid_q;
	logic              out_vld_q;
	logic              skid_vld_q;
	logic              push;
	logic              pop;
	res_t              fin_res;

	awu_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// A zero batch size acts as a batch of one.
	assign dvs = (cfg.bs == 16'd0) ? 16'd1 : cfg.bs;

	// ---------------------------------------------------------------
	// Stage functions. Each one is the logic between two pipeline registers.
	// ---------------------------------------------------------------
	function automatic rec_t f_load(logic signed [31:0] w, logic signed [31:0] m,
			logic [31:0] v, logic signed [31:0] gs);
		rec_t r;
		r      = '0;
		r.w    = w;
		r.m    = m;
		r.v    = v;
		r.gneg = gs[31];
		r.a    = gs[31] ? (~gs + 32'd1) : gs;
		return r;
	endfunction

	// One bit of |grad_sum| divided by the batch size, restoring division.
	function automatic rec_t f_div(rec_t ri, logic [15:0] d);
		rec_t        r;
		logic [16:0] t;
		logic        ge;
		r      = ri;
		t      = {r.drem, r.a[31]};
		ge     = (t >= {1'b0, d});
		t      = ge ? (t - {1'b0, d}) : t;
		r.drem = t[15:0];
		r.q    = {r.q[30:0], ge};
		r.a    = {r.a[30:0], 1'b0};
		return r;
	endfunction

	// Moment products and the gradient square, all in parallel.
	function automatic rec_t f_mul(rec_t ri);
		rec_t               r;
		logic signed [32:0] g;
		r     = ri;
		g     = r.gneg ? -$signed({1'b0, r.q}) : $signed({1'b0, r.q});
		r.pm1 = B1_Q30 * r.m;
		r.pm2 = OMB1_Q30 * g;
		r.gg  = {32'd0, r.q} * {32'd0, r.q};
		r.pv  = B2_Q30 * r.v;
		return r;
	endfunction

	// New first moment with rounding and clamp; gradient square rescaled and capped.
	function automatic rec_t f_mrnd(rec_t ri);
		rec_t               r;
		logic signed [63:0] s;
		logic [63:0]        t;
		r = ri;
		s = r.pm1 + r.pm2 + 64'sd536870912;
		s = s >>> 30;
		if (s > 64'sh7FFF_FFFF) begin
			r.m   = 32'sh7FFF_FFFF;
			r.sat = 1'b1;
		end else if (s < -64'sh8000_0000) begin
			r.m   = -32'sh8000_0000;
			r.sat = 1'b1;
		end else begin
			r.m = s[31:0];
		end
		t    = r.gg + (64'd1 << (G2_SH - 1));
		t    = t >> G2_SH;
		r.g2 = (t > {21'd0, G2_CAP}) ? G2_CAP : t[42:0];
		return r;
	endfunction

	function automatic rec_t f_vmul(rec_t ri);
		rec_t r;
		r    = ri;
		r.pg = OMB2_Q30 * r.g2;
		return r;
	endfunction

	// New second moment with rounding and saturation.
	function automatic rec_t f_vrnd(rec_t ri);
		rec_t        r;
		logic [64:0] vt;
		r  = ri;
		vt = {3'd0, r.pv} + {1'b0, r.pg} + 65'd536870912;
		vt = vt >> 30;
		if (vt > 65'hFFFF_FFFF) begin
			r.v   = 32'hFFFF_FFFF;
			r.sat = 1'b1;
		end else begin
			r.v = vt[31:0];
		end
		return r;
	endfunction

	// Bias corrections.
	function automatic rec_t f_cmul(rec_t ri, cfg_t c);
		rec_t r;
		r     = ri;
		r.mhp = r.m * $signed({1'b0, c.bc1});
		r.vb  = r.v * c.bc2;
		return r;
	endfunction

	// Round m_hat to Q.F, split sign and magnitude, seed the square root.
	function automatic rec_t f_crnd(rec_t ri);
		rec_t               r;
		logic signed [64:0] s;
		logic [64:0]        u;
		r      = ri;
		s      = r.mhp + 65'sd524288;
		s      = s >>> 20;
		r.mneg = s[64];
		u      = s[64] ? -s : s;
		r.mag  = u[43:0];
		r.sx   = r.vb;
		r.root = '0;
		r.srem = '0;
		return r;
	endfunction

	// One digit of the floor square root.
	function automatic rec_t f_sq(rec_t ri);
		rec_t        r;
		logic [35:0] t;
		logic [35:0] trial;
		logic        ge;
		r      = ri;
		t      = {r.srem[33:0], r.sx[63:62]};
		trial  = {2'd0, r.root, 2'b01};
		ge     = (t >= trial);
		r.srem = ge ? (t - trial) : t;
		r.root = {r.root[30:0], ge};
		r.sx   = {r.sx[61:0], 2'b00};
		return r;
	endfunction

	function automatic rec_t f_num(rec_t ri, cfg_t c);
		rec_t r;
		r     = ri;
		r.num = r.mag * c.lr;
		r.dd  = {1'b0, r.root} + 33'd1;
		return r;
	endfunction

	// Anything with a quotient of 2^41 or more is capped outright.
	function automatic rec_t f_qinit(rec_t ri);
		rec_t r;
		r      = ri;
		r.ovf  = ({5'd0, r.num[68:41]} >= r.dd);
		r.qrem = {6'd0, r.num[68:41]};
		r.qd   = '0;
		return r;
	endfunction

	// One quotient bit of |m_hat| * lr / (root + 1).
	function automatic rec_t f_qd(rec_t ri);
		rec_t        r;
		logic [33:0] t;
		logic        ge;
		r      = ri;
		t      = {r.qrem[32:0], r.num[40]};
		ge     = (t >= {1'b0, r.dd});
		r.qrem = ge ? (t - {1'b0, r.dd}) : t;
		r.qd   = {r.qd[39:0], ge};
		r.num  = {r.num[67:0], 1'b0};
		return r;
	endfunction

	// Signed step and the saturated weight.
	function automatic rec_t f_fin(rec_t ri);
		rec_t               r;
		logic [40:0]        smag;
		logic signed [41:0] stp;
		logic signed [42:0] wn;
		r    = ri;
		smag = (r.ovf || (r.qd > STEP_CAP)) ? STEP_CAP : r.qd;
		stp  = r.mneg ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
		wn   = 43'(r.w) - 43'(stp);
		if (wn > 43'sh7FFF_FFFF) begin
			r.w   = 32'sh7FFF_FFFF;
			r.sat = 1'b1;
		end else if (wn < -43'sh8000_0000) begin
			r.w   = -32'sh8000_0000;
			r.sat = 1'b1;
		end else begin
			r.w = wn[31:0];
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stage wiring: each register's input is a function of the one before.
	// ---------------------------------------------------------------
	for (genvar k = 0; k <= LAST; k++) begin : g_stage
		if (k == 0) begin : g_ld
			assign nxt[k] = f_load(weight_in, moment_first_in, moment_second_in, grad_sum);
		end else if (k < S_MUL) begin : g_div
			assign nxt[k] = f_div(rec_s[k-1], dvs);
		end else if (k == S_MUL) begin : g_mul
			assign nxt[k] = f_mul(rec_s[k-1]);
		end else if (k == S_MRND) begin : g_mrnd
			assign nxt[k] = f_mrnd(rec_s[k-1]);
		end else if (k == S_VMUL) begin : g_vmul
			assign nxt[k] = f_vmul(rec_s[k-1]);
		end else if (k == S_VRND) begin : g_vrnd
			assign nxt[k] = f_vrnd(rec_s[k-1]);
		end else if (k == S_CMUL) begin : g_cmul
			assign nxt[k] = f_cmul(rec_s[k-1], cfg);
		end else if (k == S_CRND) begin : g_crnd
			assign nxt[k] = f_crnd(rec_s[k-1]);
		end else if (k < S_NUM) begin : g_sq
			assign nxt[k] = f_sq(rec_s[k-1]);
		end else if (k == S_NUM) begin : g_num
			assign nxt[k] = f_num(rec_s[k-1], cfg);
		end else if (k == S_QINIT) begin : g_qinit
			assign nxt[k] = f_qinit(rec_s[k-1]);
		end else if (k < S_FIN) begin : g_qd
			assign nxt[k] = f_qd(rec_s[k-1]);
		end else begin : g_fin
			assign nxt[k] = f_fin(rec_s[k-1]);
		end
	end

	// The whole pipeline advances together unless the skid register holds a result.
	assign en       = !skid_vld_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k <= LAST; k++) begin
				rec_s[k] <= nxt[k];
			end
		end
	end

	// ---------------------------------------------------------------
	// Output register with a one-entry skid behind it.
	// ---------------------------------------------------------------
	assign fin_res = '{w: rec_s[LAST].w, m: rec_s[LAST].m, v: rec_s[LAST].v,
		sat: rec_s[LAST].sat};
	assign push = en && vld_s[LAST];
	assign pop  = out_vld_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_q <= fin_res;
			end else begin
				out_q <= fin_res;
			end
		end
	end

	assign out_valid         = out_vld_q;
	assign weight_out        = out_q.w;
	assign moment_first_out  = out_q.m;
	assign moment_second_out = out_q.v;
	assign saturated         = out_q.sat;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a result while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_ready))
		else $error("skid filled without back pressure");

	a_hold_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |=> $stable(vld_s))
		else $error("pipeline moved while the skid was full");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench of adam_weight_update_unit: directed and random weight records,
// compared against an in-bench fixed-point Adam predictor. Depends on awu_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import awu_pkg::*;

	// Cycles with no accepted beat before the run is declared hung.
	localparam int HANG_LIMIT = 3000;
	// Drain time after the last result.
	localparam int DRAIN_CYCLES = 150;
	localparam int RANDOM_PER_PHASE = 75;
	localparam int N_PHASES = 6;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid, in_ready;
	logic signed [31:0] weight_in, moment_first_in, grad_sum;
	logic [31:0] moment_second_in;
	logic out_valid, out_ready;
	logic signed [31:0] weight_out, moment_first_out;
	logic [31:0] moment_second_out;
	logic saturated;

	adam_weight_update_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.weight_in(weight_in), .moment_first_in(moment_first_in),
		.moment_second_in(moment_second_in), .grad_sum(grad_sum),
		.out_valid(out_valid), .out_ready(out_ready),
		.weight_out(weight_out), .moment_first_out(moment_first_out),
		.moment_second_out(moment_second_out), .saturated(saturated)
	);

	// Our copy of the register file, as the block should hold it after each write.
	logic [24:0] lr_shadow;
	logic [15:0] bs_shadow;
	logic [31:0] bc1_shadow, bc2_shadow;

	// Updates still owed by the block, oldest first.
	res_t pending_updates[$];
	int mismatches;
	int hang_count;
	// When set, neither side inserts idle cycles.
	bit steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor square root of a 64-bit value, digit by digit.
	function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
		logic [63:0] r, b;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// One Adam step on one weight record under the current register values.
	function automatic res_t adam_update(input logic [31:0] w_raw, input logic [31:0] m_raw,
			input logic [31:0] v_raw, input logic [31:0] gs_raw);
		res_t r;
		longint w, m, gs, bs, g, mt, mn, stp, wn;
		logic [63:0] gg, g2, vt, vn, root;
		logic signed [65:0] ma, mb, mh;
		logic [65:0] amag;
		logic [127:0] num, quo;
		r.sat = 1'b0;
		w = longint'($signed(w_raw));
		m = longint'($signed(m_raw));
		gs = longint'($signed(gs_raw));
		// A batch size of zero counts as one.
		bs = (bs_shadow == 16'd0) ? 64'sd1 : longint'({48'd0, bs_shadow});
		g = gs / bs;

		mt = 64'sd966367642 * m + 64'sd107374182 * g + (64'sd1 <<< 29);
		mn = mt >>> 30;
		if (mn > 64'sd2147483647) begin
			mn = 64'sd2147483647;
			r.sat = 1'b1;
		end else if (mn < -64'sd2147483648) begin
			mn = -64'sd2147483648;
			r.sat = 1'b1;
		end

		// The squared gradient is brought to Q.28 and capped; the cap only bites
		// where the second moment saturates anyway.
		gg = g * g;
		g2 = (gg + (64'd1 << 19)) >> 20;
		if (g2 > (64'd1 << 42))
			g2 = 64'd1 << 42;
		vt = 64'd1072668082 * {32'd0, v_raw} + 64'd1073742 * g2 + (64'd1 << 29);
		vn = vt >> 30;
		if (vn > 64'hFFFF_FFFF) begin
			vn = 64'hFFFF_FFFF;
			r.sat = 1'b1;
		end

		ma = mn;
		mb = {34'd0, bc1_shadow};
		mh = (ma * mb + 66'sd524288) >>> 20;
		amag = mh[65] ? -mh : mh;

		root = floor_sqrt(vn * {32'd0, bc2_shadow});
		num = {62'd0, amag} * {103'd0, lr_shadow};
		quo = num / ({64'd0, root} + 128'd1);
		if (quo > (128'd1 << 40))
			quo = 128'd1 << 40;
		stp = mh[65] ? -longint'(quo[63:0]) : longint'(quo[63:0]);

		wn = w - stp;
		if (wn > 64'sd2147483647) begin
			wn = 64'sd2147483647;
			r.sat = 1'b1;
		end else if (wn < -64'sd2147483648) begin
			wn = -64'sd2147483648;
			r.sat = 1'b1;
		end
		r.w = wn[31:0];
		r.m = mn[31:0];
		r.v = vn[31:0];
		return r;
	endfunction

	// Register write over the configuration port: setup cycle, then access cycle.
	// Bits above a register's width are dropped, as in the block.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_LR:  lr_shadow = value[24:0];
			REG_BS:  bs_shadow = value[15:0];
			REG_BC1: bc1_shadow = value;
			REG_BC2: bc2_shadow = value;
		endcase
	endtask

	// Wait until every owed update has come back and the pipeline is empty.
	task automatic drain();
		while (pending_updates.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Offer one weight record. Called and returning at a falling edge. When typed
	// is set the expectation is the one given, otherwise the predictor's.
	task automatic send_record(input logic [31:0] w, input logic [31:0] m,
			input logic [31:0] v, input logic [31:0] gs, input bit typed, input res_t given);
		while (!steady && $urandom_range(0, 99) < 35) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		weight_in = w;
		moment_first_in = m;
		moment_second_in = v;
		grad_sum = gs;
		pending_updates.push_back(typed ? given : adam_update(w, m, v, gs));
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// A field value that leans on the extremes but also ranges over all bits,
	// with many small magnitudes as real gradients and moments have.
	function automatic logic [31:0] pick_field();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4, 5, 6: return $signed(r) >>> $urandom_range(4, 24);
			default: return r;
		endcase
	endfunction

	// Directed records. The expected update is typed in only where it is plain
	// to see: with all moments and the gradient zero the weight passes through.
	typedef struct {
		logic [31:0] w, m, v, gs;
		bit typed;
		res_t want;
	} record_row_t;

	record_row_t directed[] = '{
		'{32'h0000_0000, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h0000_0000, 32'h0, 32'h0, 1'b0}},
		'{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0}},
		'{32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h8000_0000, 32'h0, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'h0, 32'h0, 32'h8000_0000, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		// Huge gradient on a full second moment: the squared gradient reaches the cap.
		'{32'h0100_0000, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		// Large first moment with an empty second moment: the step blows up and the
		// weight clips at either end.
		'{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		'{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		'{32'h0100_0000, 32'h0010_0000, 32'h0000_1000, 32'h0080_0000, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		'{32'hFF00_0000, 32'hFFF0_0000, 32'h1000_0000, 32'hFF80_0000, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}},
		'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '{32'h0, 32'h0, 32'h0, 1'b0}}
	};

	// Receiver: backpressure at random, changed at the falling edge.
	always @(negedge clk)
		out_ready <= steady || ($urandom_range(0, 99) >= 35);

	// Each output beat is checked against the oldest owed update.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_updates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output beat: w=%h m=%h v=%h sat=%b",
						weight_out, moment_first_out, moment_second_out, saturated);
			end else begin
				want = pending_updates.pop_front();
				if (weight_out !== want.w || moment_first_out !== want.m ||
						moment_second_out !== want.v || saturated !== want.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: w %h/%h m %h/%h v %h/%h sat %b/%b (expected/actual)",
							want.w, weight_out, want.m, moment_first_out,
							want.v, moment_second_out, want.sat, saturated);
				end
			end
		end
	end

	// Watchdog: any accepted beat on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			hang_count <= 0;
		end else begin
			hang_count <= hang_count + 1;
			if (hang_count >= HANG_LIMIT) begin
				$display("adam_weight_update_unit verification failed");
				$finish;
			end
		end
	end

	initial begin
		res_t none;
		none = '0;
		mismatches = 0;
		hang_count = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		weight_in = '0;
		moment_first_in = '0;
		moment_second_in = '0;
		grad_sum = '0;
		out_ready = 1'b0;
		lr_shadow = LR_RST;
		bs_shadow = BS_RST;
		bc1_shadow = BC_RST;
		bc2_shadow = BC_RST;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int phase = 0; phase < N_PHASES; phase++) begin
			// Each phase runs under its own register setting, written while idle.
			case (phase)
				0: ;
				1: begin
					// Upper bits of the step size are dropped; zero batch size acts as one.
					write_reg(REG_LR, 32'hFFFF_FFFF);
					write_reg(REG_BS, 32'hFFFF_0000);
					write_reg(REG_BC1, 32'hFFFF_FFFF);
					write_reg(REG_BC2, 32'h0000_0000);
				end
				2: begin
					write_reg(REG_LR, 32'h0000_0000);
					write_reg(REG_BS, 32'h0000_FFFF);
					write_reg(REG_BC1, 32'h0000_0000);
					write_reg(REG_BC2, 32'hFFFF_FFFF);
				end
				3: begin
					write_reg(REG_LR, 32'h0100_0000);
					write_reg(REG_BS, 32'h0000_0001);
					write_reg(REG_BC1, 32'h0010_0000);
					write_reg(REG_BC2, 32'h0010_0000);
				end
				default: begin
					write_reg(REG_LR, $urandom);
					write_reg(REG_BS, ($urandom_range(0, 3) == 0) ? $urandom
						: $urandom_range(1, 64));
					write_reg(REG_BC1, 32'h0010_0000 + $urandom_range(0, 32'h00A0_0000));
					write_reg(REG_BC2, ($urandom_range(0, 3) == 0) ? $urandom
						: 32'h0010_0000 + $urandom_range(0, 32'h3E80_0000));
				end
			endcase
			// The phase at unit step size runs with both sides at full rate.
			steady = (phase == 3);

			// Typed expectations only hold under the reset registers.
			if (phase < 2)
				foreach (directed[i])
					send_record(directed[i].w, directed[i].m, directed[i].v, directed[i].gs,
						directed[i].typed && phase == 0, directed[i].want);

			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// Halfway through one phase the sender holds off until all is back.
				if (phase == 4 && n == RANDOM_PER_PHASE / 2) begin
					in_valid = 1'b0;
					while (pending_updates.size() != 0)
						@(negedge clk);
				end
				send_record(pick_field(), pick_field(), pick_field(), pick_field(), 1'b0, none);
			end
			in_valid = 1'b0;
			drain();
		end

		if (mismatches == 0) begin
			$display("adam_weight_update_unit verification clean");
		end else begin
			$display("adam_weight_update_unit verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
